// File: sv/hslrgb_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// hslrgb_pkg
// Shared constants and types for the HSL to RGB converter.
// ============================================================================
package hslrgb_pkg;

    // Field widths
    localparam int IN_W  = 16;
    localparam int OUT_W = 8;

    // Scales: saturation/lightness use 65535 as 1.0, hue uses 65536 as 1.0
    localparam logic [16:0] UNIT_SL = 17'd65535;
    localparam logic [16:0] HUE_ONE = 17'd65536;

    // Internal widths
    localparam int T_W    = 17;  // hue position term, 0..65536
    localparam int N_W    = 32;  // chroma numerator a * s
    localparam int K_W    = 33;  // 2 * l * 65535 - n
    localparam int XP_W   = 49;  // n * t
    localparam int W_W    = 51;  // channel numerator over D / 255
    localparam int P_W    = W_W + 8;
    localparam int Y_W    = P_W - 17;
    localparam int Q0_W   = Y_W - 32;
    localparam int R_W    = 33;
    localparam int NUM_CH = 3;
    localparam int STAGES = 7;

    // Common denominator 2 * 65535^2 * 65536
    localparam logic [W_W-1:0] DEN =
        W_W'(64'd2 * 64'd65535 * 64'd65535 * 64'd65536);
    // 65535^2, divisor of the final quotient step
    localparam logic [R_W-1:0] U2      = R_W'(64'd4294836225);
    localparam logic [R_W-1:0] R_LIMIT = R_W'(64'd8589672450);
    localparam logic [Q0_W-1:0] Q0_MAX = Q0_W'(255);
    localparam logic [OUT_W-1:0] CH_MAX = 8'd255;

    // Sixth of the hue circle
    typedef enum logic [2:0] {
        SIX_RED_YEL = 3'd0,
        SIX_YEL_GRN = 3'd1,
        SIX_GRN_CYN = 3'd2,
        SIX_CYN_BLU = 3'd3,
        SIX_BLU_MAG = 3'd4,
        SIX_MAG_RED = 3'd5
    } sixth_t;

    // Channel lanes
    localparam int CH_R = 0;
    localparam int CH_G = 1;
    localparam int CH_B = 2;

endpackage

// File: sv/hsl_to_rgb_converter_unit.sv
`timescale 1ns / 1ps
// Each stage is one register; an accepted item reaches m_valid through all of them.
// Throughput: one item per cycle while m_ready holds no result back; each stage stalls only when the stage after
// it is full and blocked, so bubbles collapse under output back-pressure.
// Reset (aresetn low at a clock edge) clears all stage valid bits; datapath
// registers are not reset.
// ============================================================================
// hsl_to_rgb_converter_unit
// Fixed-point HSL to 8-bit RGB conversion in a seven-stage pipeline.
// ============================================================================
module hsl_to_rgb_converter_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [hslrgb_pkg::IN_W-1:0]    s_hue,
    input  logic [hslrgb_pkg::IN_W-1:0]    s_saturation,
    input  logic [hslrgb_pkg::IN_W-1:0]    s_lightness,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [hslrgb_pkg::OUT_W-1:0]   m_red,
    output logic [hslrgb_pkg::OUT_W-1:0]   m_green,
    output logic [hslrgb_pkg::OUT_W-1:0]   m_blue
);

    localparam int S = hslrgb_pkg::STAGES;

    // ------------------------------------------------------------------
    // Stage control
    // ------------------------------------------------------------------
    logic [S-1:0] v_reg;
    logic [S-1:0] v_next;
    logic [S-1:0] en;

    // A stage loads when it is empty or its content moves on
    always_comb begin
        en[S-1] = !v_reg[S-1] || m_ready;
        for (int i = S - 2; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    always_comb begin
        v_next[0] = en[0] ? s_valid : v_reg[0];
        for (int i = 1; i < S; i++) begin
            v_next[i] = en[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_ready = en[0];
    assign m_valid = v_reg[S-1];

    // ------------------------------------------------------------------
    // Stage 1: 1 - |2l - 1| and hue position within its pair of sixths
    // ------------------------------------------------------------------
    logic [16:0]                      twol;
    logic [16:0]                      ldist;
    logic [18:0]                      h6;
    logic [16:0]                      p;
    logic [16:0]                      dp;
    logic [hslrgb_pkg::IN_W-1:0]      a_next;
    logic [hslrgb_pkg::T_W-1:0]       t1_next;

    logic [hslrgb_pkg::IN_W-1:0]      a_reg;
    logic [hslrgb_pkg::IN_W-1:0]      sat1_reg;
    logic [hslrgb_pkg::IN_W-1:0]      lit1_reg;
    hslrgb_pkg::sixth_t               sixth1_reg;
    logic [hslrgb_pkg::T_W-1:0]       t1_reg;

    always_comb begin
        twol    = {s_lightness, 1'b0};
        ldist   = (twol >= hslrgb_pkg::UNIT_SL) ? twol - hslrgb_pkg::UNIT_SL
                                                : hslrgb_pkg::UNIT_SL - twol;
        a_next  = 16'(hslrgb_pkg::UNIT_SL - ldist);
        h6      = {1'b0, s_hue, 2'b00} + {2'b00, s_hue, 1'b0};
        p       = h6[16:0];
        dp      = (p >= hslrgb_pkg::HUE_ONE) ? p - hslrgb_pkg::HUE_ONE
                                             : hslrgb_pkg::HUE_ONE - p;
        t1_next = hslrgb_pkg::HUE_ONE - dp;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            a_reg      <= a_next;
            sat1_reg   <= s_saturation;
            lit1_reg   <= s_lightness;
            sixth1_reg <= hslrgb_pkg::sixth_t'(h6[18:16]);
            t1_reg     <= t1_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: chroma numerator n = a * s
    // ------------------------------------------------------------------
    logic [hslrgb_pkg::N_W-1:0]       n2_reg;
    logic [hslrgb_pkg::IN_W-1:0]      lit2_reg;
    hslrgb_pkg::sixth_t               sixth2_reg;
    logic [hslrgb_pkg::T_W-1:0]       t2_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            n2_reg     <= hslrgb_pkg::N_W'(a_reg) * hslrgb_pkg::N_W'(sat1_reg);
            lit2_reg   <= lit1_reg;
            sixth2_reg <= sixth1_reg;
            t2_reg     <= t1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: secondary product n * t and offset term 2*l*65535 - n
    // ------------------------------------------------------------------
    logic [31:0]                      litu;
    logic [hslrgb_pkg::K_W-1:0]       k_next;

    logic [hslrgb_pkg::XP_W-1:0]      xp3_reg;
    logic [hslrgb_pkg::K_W-1:0]       k3_reg;
    logic [hslrgb_pkg::N_W-1:0]       n3_reg;
    hslrgb_pkg::sixth_t               sixth3_reg;

    always_comb begin
        litu   = {lit2_reg, 16'h0000} - {16'h0000, lit2_reg};
        k_next = {litu, 1'b0} - {1'b0, n2_reg};
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            xp3_reg    <= hslrgb_pkg::XP_W'(n2_reg) * hslrgb_pkg::XP_W'(t2_reg);
            k3_reg     <= k_next;
            n3_reg     <= n2_reg;
            sixth3_reg <= sixth2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: channel numerators and arrangement by hue sixth
    // ------------------------------------------------------------------
    logic [hslrgb_pkg::W_W-1:0] wk;
    logic [hslrgb_pkg::W_W-1:0] wc;
    logic [hslrgb_pkg::W_W-1:0] wx;
    logic [hslrgb_pkg::W_W-1:0] w_next [hslrgb_pkg::NUM_CH];
    logic [hslrgb_pkg::W_W-1:0] w4_reg [hslrgb_pkg::NUM_CH];

    always_comb begin
        wk = hslrgb_pkg::W_W'({k3_reg, 16'h0000});
        wc = hslrgb_pkg::W_W'({n3_reg, 17'h00000}) + wk;
        wx = hslrgb_pkg::W_W'({xp3_reg, 1'b0}) + wk;
        case (sixth3_reg)
            hslrgb_pkg::SIX_RED_YEL: begin
                w_next[hslrgb_pkg::CH_R] = wc;
                w_next[hslrgb_pkg::CH_G] = wx;
                w_next[hslrgb_pkg::CH_B] = wk;
            end
            hslrgb_pkg::SIX_YEL_GRN: begin
                w_next[hslrgb_pkg::CH_R] = wx;
                w_next[hslrgb_pkg::CH_G] = wc;
                w_next[hslrgb_pkg::CH_B] = wk;
            end
            hslrgb_pkg::SIX_GRN_CYN: begin
                w_next[hslrgb_pkg::CH_R] = wk;
                w_next[hslrgb_pkg::CH_G] = wc;
                w_next[hslrgb_pkg::CH_B] = wx;
            end
            hslrgb_pkg::SIX_CYN_BLU: begin
                w_next[hslrgb_pkg::CH_R] = wk;
                w_next[hslrgb_pkg::CH_G] = wx;
                w_next[hslrgb_pkg::CH_B] = wc;
            end
            hslrgb_pkg::SIX_BLU_MAG: begin
                w_next[hslrgb_pkg::CH_R] = wx;
                w_next[hslrgb_pkg::CH_G] = wk;
                w_next[hslrgb_pkg::CH_B] = wc;
            end
            default: begin
                w_next[hslrgb_pkg::CH_R] = wc;
                w_next[hslrgb_pkg::CH_G] = wk;
                w_next[hslrgb_pkg::CH_B] = wx;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            for (int c = 0; c < hslrgb_pkg::NUM_CH; c++) begin
                w4_reg[c] <= w_next[c];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: scale by 255 and drop the 2^17 part of the denominator
    // ------------------------------------------------------------------
    logic [hslrgb_pkg::P_W-1:0] prod  [hslrgb_pkg::NUM_CH];
    logic [hslrgb_pkg::Y_W-1:0] y5_reg [hslrgb_pkg::NUM_CH];

    always_comb begin
        for (int c = 0; c < hslrgb_pkg::NUM_CH; c++) begin
            prod[c] = {w4_reg[c], 8'h00} - hslrgb_pkg::P_W'(w4_reg[c]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            for (int c = 0; c < hslrgb_pkg::NUM_CH; c++) begin
                y5_reg[c] <= prod[c][hslrgb_pkg::P_W-1:17];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: divide by 65535^2, estimate y >> 32 and its remainder
    // ------------------------------------------------------------------
    logic [hslrgb_pkg::Q0_W-1:0] q0_next [hslrgb_pkg::NUM_CH];
    logic [hslrgb_pkg::R_W-1:0]  r_next  [hslrgb_pkg::NUM_CH];
    logic [hslrgb_pkg::Q0_W-1:0] q06_reg [hslrgb_pkg::NUM_CH];
    logic [hslrgb_pkg::R_W-1:0]  r6_reg  [hslrgb_pkg::NUM_CH];

    // q0 * 65535^2 = q0 * 2^32 - q0 * 2^17 + q0
    always_comb begin
        for (int c = 0; c < hslrgb_pkg::NUM_CH; c++) begin
            q0_next[c] = y5_reg[c][hslrgb_pkg::Y_W-1:32];
            r_next[c]  = {1'b0, y5_reg[c][31:0]}
                       + hslrgb_pkg::R_W'({q0_next[c], 17'h00000})
                       - hslrgb_pkg::R_W'(q0_next[c]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            for (int c = 0; c < hslrgb_pkg::NUM_CH; c++) begin
                q06_reg[c] <= q0_next[c];
                r6_reg[c]  <= r_next[c];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: quotient correction and saturation at 255
    // ------------------------------------------------------------------
    logic [hslrgb_pkg::Q0_W:0]    q_full  [hslrgb_pkg::NUM_CH];
    logic [hslrgb_pkg::OUT_W-1:0] ch_next [hslrgb_pkg::NUM_CH];
    logic [hslrgb_pkg::OUT_W-1:0] ch7_reg [hslrgb_pkg::NUM_CH];

    always_comb begin
        for (int c = 0; c < hslrgb_pkg::NUM_CH; c++) begin
            q_full[c]  = {1'b0, q06_reg[c]}
                       + (hslrgb_pkg::Q0_W + 1)'(r6_reg[c] >= hslrgb_pkg::U2);
            ch_next[c] = (q_full[c] > (hslrgb_pkg::Q0_W + 1)'(hslrgb_pkg::CH_MAX))
                       ? hslrgb_pkg::CH_MAX
                       : q_full[c][hslrgb_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            for (int c = 0; c < hslrgb_pkg::NUM_CH; c++) begin
                ch7_reg[c] <= ch_next[c];
            end
        end
    end

    assign m_red   = ch7_reg[hslrgb_pkg::CH_R];
    assign m_green = ch7_reg[hslrgb_pkg::CH_G];
    assign m_blue  = ch7_reg[hslrgb_pkg::CH_B];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> v_reg[0])
        else $error("accepted item not held in first stage");

    a_num_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[3] |-> (w4_reg[0] <= hslrgb_pkg::DEN && w4_reg[1] <= hslrgb_pkg::DEN
                      && w4_reg[2] <= hslrgb_pkg::DEN))
        else $error("channel numerator above full scale");

    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[5] |-> (q06_reg[0] <= hslrgb_pkg::Q0_MAX && r6_reg[0] < hslrgb_pkg::R_LIMIT
                      && q06_reg[1] <= hslrgb_pkg::Q0_MAX && r6_reg[1] < hslrgb_pkg::R_LIMIT
                      && q06_reg[2] <= hslrgb_pkg::Q0_MAX && r6_reg[2] < hslrgb_pkg::R_LIMIT))
        else $error("quotient estimate off by more than one");

endmodule

// File: tb/hsl_to_rgb_converter_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// hsl_to_rgb_converter_unit_tb
// Drives HSL pixels into the converter and checks each RGB result against an
// exact integer model of the conversion. Both handshake sides idle at random.
// ============================================================================
module hsl_to_rgb_converter_unit_tb;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 16;

    // Exact conversion scales: 65535 is 1.0 for S and L, 65536 for hue
    localparam longint unsigned SL_SCALE  = 64'd65535;
    localparam longint unsigned HUE_SCALE = 64'd65536;
    localparam longint unsigned COMMON_DEN =
        64'd2 * SL_SCALE * SL_SCALE * HUE_SCALE;

    typedef struct {
        logic [hslrgb_pkg::IN_W-1:0]  hue;
        logic [hslrgb_pkg::IN_W-1:0]  sat;
        logic [hslrgb_pkg::IN_W-1:0]  lit;
        logic [hslrgb_pkg::OUT_W-1:0] red;
        logic [hslrgb_pkg::OUT_W-1:0] green;
        logic [hslrgb_pkg::OUT_W-1:0] blue;
    } pixel_rgb_t;

    logic                         aclk         = 1'b0;
    logic                         aresetn      = 1'b0;
    logic                         s_valid      = 1'b0;
    logic                         s_ready;
    logic [hslrgb_pkg::IN_W-1:0]  s_hue        = '0;
    logic [hslrgb_pkg::IN_W-1:0]  s_saturation = '0;
    logic [hslrgb_pkg::IN_W-1:0]  s_lightness  = '0;
    logic                         m_valid;
    logic                         m_ready      = 1'b0;
    logic [hslrgb_pkg::OUT_W-1:0] m_red;
    logic [hslrgb_pkg::OUT_W-1:0] m_green;
    logic [hslrgb_pkg::OUT_W-1:0] m_blue;

    pixel_rgb_t rgb_expected_q[$];
    pixel_rgb_t rgb_head;
    int         fail_count  = 0;
    int         cycle_count = 0;
    int         rx_stall    = 0;
    bit         tx_idle_en  = 1'b1;
    bit         rx_idle_en  = 1'b1;

    hsl_to_rgb_converter_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_hue        (s_hue),
        .s_saturation (s_saturation),
        .s_lightness  (s_lightness),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue)
    );

    always #5 aclk = ~aclk;

    // Run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // One channel: floor(255 * (v + m)) over the common denominator, capped
    function automatic logic [hslrgb_pkg::OUT_W-1:0] scale_channel(longint unsigned vnum,
                                                                   longint unsigned mnum);
        longint unsigned q;
        q = (64'd255 * (vnum + mnum)) / COMMON_DEN;
        return (q > 64'd255) ? hslrgb_pkg::CH_MAX : q[hslrgb_pkg::OUT_W-1:0];
    endfunction

    // Exact HSL to RGB conversion of one pixel
    function automatic pixel_rgb_t predict_rgb(logic [hslrgb_pkg::IN_W-1:0] hue,
                                               logic [hslrgb_pkg::IN_W-1:0] sat,
                                               logic [hslrgb_pkg::IN_W-1:0] lit);
        pixel_rgb_t         res;
        longint unsigned    h, s, l, twol, ldist, chroma_n, h6, pos, dpos, tri_w;
        longint unsigned    cnum, xnum, mnum, rv, gv, bv;
        hslrgb_pkg::sixth_t sixth;
        h = hue;
        s = sat;
        l = lit;
        // chroma numerator: (1 - |2l - 1|) * s on the 65535^2 scale
        twol     = 2 * l;
        ldist    = (twol >= SL_SCALE) ? twol - SL_SCALE : SL_SCALE - twol;
        chroma_n = (SL_SCALE - ldist) * s;
        // sixth and triangle weight within the pair of sixths
        h6    = h * 6;
        sixth = hslrgb_pkg::sixth_t'(3'(h6 >> 16));
        pos   = h6 & 64'h1FFFF;
        dpos  = (pos >= HUE_SCALE) ? pos - HUE_SCALE : HUE_SCALE - pos;
        tri_w = HUE_SCALE - dpos;
        cnum  = 2 * HUE_SCALE * chroma_n;
        xnum  = 2 * chroma_n * tri_w;
        mnum  = HUE_SCALE * (2 * l * SL_SCALE - chroma_n);
        case (sixth)
            hslrgb_pkg::SIX_RED_YEL: begin rv = cnum; gv = xnum; bv = 0;    end
            hslrgb_pkg::SIX_YEL_GRN: begin rv = xnum; gv = cnum; bv = 0;    end
            hslrgb_pkg::SIX_GRN_CYN: begin rv = 0;    gv = cnum; bv = xnum; end
            hslrgb_pkg::SIX_CYN_BLU: begin rv = 0;    gv = xnum; bv = cnum; end
            hslrgb_pkg::SIX_BLU_MAG: begin rv = xnum; gv = 0;    bv = cnum; end
            default:                 begin rv = cnum; gv = 0;    bv = xnum; end
        endcase
        res.hue   = hue;
        res.sat   = sat;
        res.lit   = lit;
        res.red   = scale_channel(rv, mnum);
        res.green = scale_channel(gv, mnum);
        res.blue  = scale_channel(bv, mnum);
        return res;
    endfunction

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Field value biased toward the ends and the midpoint
    function automatic logic [hslrgb_pkg::IN_W-1:0] corner_word();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'd32767;
            3: return 16'd32768;
            4: return 16'd65534;
            5: return 16'd65535;
            default: return hslrgb_pkg::IN_W'($urandom);
        endcase
    endfunction

    // First hue of sixth k, i.e. ceil(k * 65536 / 6)
    function automatic logic [hslrgb_pkg::IN_W-1:0] sixth_start(int k);
        return hslrgb_pkg::IN_W'((k * 65536 + 5) / 6);
    endfunction

    // Result check and receiver stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (rgb_expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result r=%0d g=%0d b=%0d",
                                 $realtime, m_red, m_green, m_blue);
                end else begin
                    rgb_head = rgb_expected_q.pop_front();
                    if (m_red !== rgb_head.red || m_green !== rgb_head.green ||
                        m_blue !== rgb_head.blue) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display(
                                "%0t: mismatch hsl=%0d/%0d/%0d exp %0d/%0d/%0d got %0d/%0d/%0d",
                                $realtime, rgb_head.hue, rgb_head.sat,
                                rgb_head.lit, rgb_head.red, rgb_head.green,
                                rgb_head.blue, m_red, m_green, m_blue);
                    end
                end
            end
            if (rx_stall > 0) begin
                m_ready <= 1'b0;
                rx_stall--;
            end else begin
                m_ready <= 1'b1;
                if (rx_idle_en)
                    rx_stall = pick_gap();
            end
        end
    end

    // Present one pixel and hold it until accepted
    task automatic send_pixel(logic [hslrgb_pkg::IN_W-1:0] hue,
                              logic [hslrgb_pkg::IN_W-1:0] sat,
                              logic [hslrgb_pkg::IN_W-1:0] lit);
        s_valid      <= 1'b1;
        s_hue        <= hue;
        s_saturation <= sat;
        s_lightness  <= lit;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        rgb_expected_q.push_back(predict_rgb(hue, sat, lit));
    endtask

    task automatic sender_gap();
        int n;
        n = tx_idle_en ? pick_gap() : 0;
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // Hold off new items until every result is back
    task automatic wait_drain();
        if (rgb_expected_q.size() != 0) begin
            s_valid <= 1'b0;
            while (rgb_expected_q.size() != 0) @(posedge aclk);
        end
    endtask

    // Extremes, gray, exact white and every sixth with its boundaries
    task automatic test_directed();
        send_pixel(16'd0,     16'd0,     16'd0);
        send_pixel(16'd65535, 16'd65535, 16'd65535);
        send_pixel(16'd0,     16'd65535, 16'd32767);
        send_pixel(16'd0,     16'd65535, 16'd32768);
        send_pixel(16'd12345, 16'd0,     16'd40000);
        send_pixel(16'd54321, 16'd0,     16'd65535);
        send_pixel(16'd32768, 16'd65535, 16'd0);
        send_pixel(16'd65535, 16'd65535, 16'd32767);
        for (int k = 0; k < 6; k++)
            send_pixel(sixth_start(k) + 16'd5461, 16'd65535, 16'd32767);
        for (int k = 1; k < 6; k++) begin
            send_pixel(sixth_start(k) - 16'd1, 16'd65535, 16'd32768);
            send_pixel(sixth_start(k),         16'd40000, 16'd20000);
        end
        wait_drain();
    endtask

    // Uniform random pixels, idling switched on and off in stretches
    task automatic test_random_pixels(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 0) begin
                tx_idle_en = ($urandom_range(0, 3) != 0);
                rx_idle_en = ($urandom_range(0, 3) != 0);
            end
            if (i == count / 2)
                wait_drain();
            send_pixel(hslrgb_pkg::IN_W'($urandom), hslrgb_pkg::IN_W'($urandom),
                       hslrgb_pkg::IN_W'($urandom));
            sender_gap();
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // Corner values of S and L, hues on and around sixth boundaries
    task automatic test_corner_pixels(int count);
        logic [hslrgb_pkg::IN_W-1:0] hue;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 1) != 0)
                hue = sixth_start($urandom_range(0, 5)) +
                      hslrgb_pkg::IN_W'($urandom_range(0, 4)) - 16'd2;
            else
                hue = corner_word();
            send_pixel(hue, corner_word(), corner_word());
            sender_gap();
        end
    endtask

    // Back-to-back burst at full rate on both sides
    task automatic test_streaming(int count);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        for (int i = 0; i < count; i++)
            send_pixel(hslrgb_pkg::IN_W'($urandom), hslrgb_pkg::IN_W'($urandom),
                       hslrgb_pkg::IN_W'($urandom));
        wait_drain();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_pixels(1000);
        test_corner_pixels(600);
        test_streaming(300);
        test_random_pixels(100);

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && rgb_expected_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
